FILE: rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the chunk frame receiver
// Item structs, verdict and reason codes, register indexes, front/back record.
// ----------------------------------------------------------------------------
package cfr_pkg;

	localparam int unsigned MaxFrames   = 10000;
	localparam int unsigned MaxSeqErrors = 10;
	localparam int unsigned QDepth      = 4;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [1:0]  verdict;
		logic [3:0]  reason;
		logic        transfer_done;
		logic [23:0] total_length;
		logic        last;
	} out_item_t;

	localparam logic [1:0] V_ACK = 2'd0;
	localparam logic [1:0] V_NACK = 2'd1;
	localparam logic [1:0] V_NACK_ABORT = 2'd2;
	localparam logic [1:0] V_SILENT = 2'd3;

	localparam logic [3:0] R_OK = 4'd0;
	localparam logic [3:0] R_HS_VER = 4'd1;
	localparam logic [3:0] R_HS_TYPE = 4'd2;
	localparam logic [3:0] R_HS_LEN = 4'd3;
	localparam logic [3:0] R_HS_SUM = 4'd4;
	localparam logic [3:0] R_MAGIC = 4'd5;
	localparam logic [3:0] R_FRAMES = 4'd6;
	localparam logic [3:0] R_VER = 4'd7;
	localparam logic [3:0] R_CHUNK = 4'd8;
	localparam logic [3:0] R_TOTAL = 4'd9;
	localparam logic [3:0] R_SEQ = 4'd10;
	localparam logic [3:0] R_SEQ_MANY = 4'd11;
	localparam logic [3:0] R_SUM = 4'd12;

	localparam logic [2:0] REG_VERSION = 3'd0;
	localparam logic [2:0] REG_HS_TYPE = 3'd1;
	localparam logic [2:0] REG_FINAL_TYPE = 3'd2;
	localparam logic [2:0] REG_MAGIC = 3'd3;
	localparam logic [2:0] REG_MAX_CHUNK = 3'd4;
	localparam logic [2:0] REG_MAX_TOTAL = 3'd5;

	// one result pair from the parser: an optional byte result, then an
	// optional verdict result
	typedef struct packed {
		logic        has_byte;
		logic [7:0]  data;
		logic [23:0] byte_total; // total seen by the byte result
		logic        has_verdict;
		logic [1:0]  verdict;
		logic [3:0]  reason;
		logic        done;
		logic [23:0] total;
	} ev_t;

	// mod-255 add of two residues (each below 255)
	function automatic logic [7:0] add255(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 9'd255) s = s - 9'd255;
		return s[7:0];
	endfunction

endpackage

FILE: rtl/chunk_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// chunk_frame_receiver_core: byte-serial sequenced frame receiver
// Parses handshake and data frames, checks Fletcher-16, sequence and limits.
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// in       | input     | in_valid/in_stall   | in_data (in_item_t)
// out      | output    | out_valid/out_stall | out_data (out_item_t)
// cfg      | input     | cfg_we              | cfg_index, cfg_wdata
//
// One byte per cycle while in_stall is low: the parser updates all frame state as each byte is taken.
// Results pass through a 4-entry queue; a byte with a verdict leaves as two
// items, the byte and then the verdict. in_stall rises only when the queue is full.
// Reset clears parser state and queue; registers return to their reset values.
module chunk_frame_receiver_core
	import cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	logic [7:0]  ver_q, hst_q, fin_q;
	logic [31:0] magic_q;
	logic [15:0] maxc_q;
	logic [23:0] maxt_q;
	logic        take, ev_valid, full, empty;
	ev_t         ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q <= 8'd1; hst_q <= 8'd0; fin_q <= 8'd2; magic_q <= '0;
			maxc_q <= 16'd8192; maxt_q <= 24'd1048576;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VERSION: ver_q <= cfg_wdata[7:0];
				REG_HS_TYPE: hst_q <= cfg_wdata[7:0];
				REG_FINAL_TYPE: fin_q <= cfg_wdata[7:0];
				REG_MAGIC: magic_q <= cfg_wdata;
				REG_MAX_CHUNK: maxc_q <= cfg_wdata[15:0];
				REG_MAX_TOTAL: maxt_q <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	assign in_stall = full;
	assign take = in_valid && !in_stall;

	cfr_parser u_parser (
		.clk, .arst_n, .take, .item(in_data),
		.version_cfg(ver_q), .handshake_type_code(hst_q),
		.final_type_code(fin_q), .magic_word(magic_q),
		.max_chunk_length(maxc_q), .max_total_length(maxt_q),
		.ev_valid, .ev
	);

	cfr_emitter u_emit (
		.clk, .arst_n, .ev_valid, .ev, .full, .empty,
		.valid(out_valid), .stall(out_stall), .result(out_data)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !ev_valid) else $error("push into full queue");
	a_byte_has_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.kind) |-> (out_data.verdict == V_ACK
		&& out_data.reason == R_OK)) else $error("byte item carries verdict");
	a_empty_no_valid: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !out_valid) else $error("valid with empty queue");

endmodule

FILE: rtl/cfr_parser.sv
// ----------------------------------------------------------------------------
// cfr_parser: front part of the receiver
// Accepts bytes, tracks frame phase, checksum and limits, and emits result
// records into the queue.
// ----------------------------------------------------------------------------
module cfr_parser
	import cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  in_item_t    item,
	input  logic [7:0]  version_cfg,
	input  logic [7:0]  handshake_type_code,
	input  logic [7:0]  final_type_code,
	input  logic [31:0] magic_word,
	input  logic [15:0] max_chunk_length,
	input  logic [23:0] max_total_length,
	output logic        ev_valid,
	output ev_t         ev
);

	typedef enum logic [2:0] {
		PH_HS_HEAD, PH_HS_MAGIC, PH_HEAD, PH_SEQ, PH_DATA, PH_SKIP, PH_DONE, PH_ABORT
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [63:0] shift_q, shift_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] flen_q, flen_d;
	logic [7:0]  ftype_q, ftype_d;
	logic [15:0] xsum_q, xsum_d;
	logic [7:0]  slo_q, slo_d, shi_q, shi_d;
	logic [15:0] xseq_q, xseq_d;
	logic [23:0] total_q, total_d;
	logic [13:0] fcnt_q, fcnt_d;
	logic [3:0]  serr_q, serr_d;

	logic [7:0]  b, nlo, nhi;
	logic [63:0] sh;
	logic [15:0] cnt1;
	logic [31:0] len;
	logic [24:0] sumtot;
	logic [3:0]  serr_inc;

	always_comb begin
		b = item.rx_byte;
		nlo = add255(slo_q, b);
		nhi = add255(shi_q, nlo);
		sh = {shift_q[55:0], b};
		cnt1 = cnt_q + 16'd1;
		len = sh[63:32];
		sumtot = {1'b0, total_q} + {1'b0, flen_q};
		serr_inc = (serr_q < 4'd15) ? serr_q + 4'd1 : serr_q;

		phase_d = phase_q; shift_d = shift_q; cnt_d = cnt_q; flen_d = flen_q;
		ftype_d = ftype_q; xsum_d = xsum_q; slo_d = slo_q; shi_d = shi_q;
		xseq_d = xseq_q; total_d = total_q; fcnt_d = fcnt_q; serr_d = serr_q;
		ev = '0;

		if (item.restart) begin
			phase_d = PH_HS_HEAD; shift_d = '0; cnt_d = '0; flen_d = '0; ftype_d = '0;
			xsum_d = '0; slo_d = '0; shi_d = '0; xseq_d = '0; total_d = '0;
			fcnt_d = '0; serr_d = '0;
		end else begin
			case (phase_q)
				PH_HS_HEAD, PH_HEAD: begin
					if (phase_q == PH_HEAD && cnt_q == '0
						&& fcnt_q >= 14'(MaxFrames)) begin
						phase_d = PH_ABORT;
						ev.has_verdict = 1'b1; ev.verdict = V_SILENT; ev.reason = R_FRAMES;
					end else begin
						if (phase_q == PH_HEAD && cnt_q == '0) fcnt_d = fcnt_q + 14'd1;
						shift_d = sh;
						cnt_d = cnt1;
						if (cnt1 == 16'd8) begin
							cnt_d = '0;
							xsum_d = sh[15:0];
							ftype_d = sh[47:40];
							shift_d = '0; slo_d = '0; shi_d = '0;
							if (phase_q == PH_HS_HEAD) begin
								if (sh[31:24] != version_cfg) begin
									ev.reason = R_HS_VER;
								end else if (sh[23:16] != handshake_type_code) begin
									ev.reason = R_HS_TYPE;
								end else if (len != 32'd4) begin
									ev.reason = R_HS_LEN;
								end
								if (ev.reason != R_OK) begin
									phase_d = PH_ABORT;
									ev.has_verdict = 1'b1; ev.verdict = V_SILENT;
								end else begin
									phase_d = PH_HS_MAGIC;
								end
							end else begin
								if (sh[31:24] != version_cfg) begin
									ev.reason = R_VER;
								end else if (len > {16'd0, max_chunk_length}) begin
									ev.reason = R_CHUNK;
								end else if ({1'b0, total_q} + {9'd0, len[15:0]}
									> {1'b0, max_total_length}) begin
									ev.reason = R_TOTAL;
								end
								if (ev.reason != R_OK) begin
									phase_d = PH_ABORT;
									ev.has_verdict = 1'b1; ev.verdict = V_NACK_ABORT;
								end else begin
									flen_d = len[15:0];
									phase_d = PH_SEQ;
								end
							end
							ftype_d = sh[23:16];
						end
					end
				end
				PH_HS_MAGIC: begin
					slo_d = nlo; shi_d = nhi;
					shift_d = sh;
					cnt_d = cnt1;
					if (cnt1 == 16'd4) begin
						cnt_d = '0;
						shift_d = '0;
						ev.has_verdict = 1'b1;
						if ({nhi, nlo} != xsum_q) begin
							phase_d = PH_ABORT; ev.verdict = V_SILENT; ev.reason = R_HS_SUM;
						end else if (sh[31:0] != magic_word) begin
							phase_d = PH_ABORT; ev.verdict = V_SILENT; ev.reason = R_MAGIC;
						end else begin
							xseq_d = '0; total_d = '0; fcnt_d = '0; serr_d = '0;
							phase_d = PH_HEAD; ev.verdict = V_ACK;
						end
					end
				end
				PH_SEQ: begin
					shift_d = sh;
					cnt_d = cnt1;
					if (cnt1 == 16'd2) begin
						cnt_d = '0;
						shift_d = '0;
						if (sh[15:0] != xseq_q) begin
							serr_d = serr_inc;
							ev.has_verdict = 1'b1;
							if (serr_inc >= 4'(MaxSeqErrors)) begin
								phase_d = PH_ABORT; ev.verdict = V_NACK_ABORT;
								ev.reason = R_SEQ_MANY;
							end else begin
								phase_d = (flen_q == '0) ? PH_HEAD : PH_SKIP;
								ev.verdict = V_NACK; ev.reason = R_SEQ;
							end
						end else begin
							serr_d = '0;
							if (flen_q == '0) begin
								ev.has_verdict = 1'b1;
								if ({shi_q, slo_q} != xsum_q) begin
									phase_d = PH_HEAD; ev.verdict = V_NACK; ev.reason = R_SUM;
								end else begin
									total_d = sumtot[23:0];
									xseq_d = xseq_q + 16'd1;
									ev.verdict = V_ACK;
									ev.done = (ftype_q == final_type_code);
									phase_d = ev.done ? PH_DONE : PH_HEAD;
								end
							end else begin
								phase_d = PH_DATA;
							end
						end
					end
				end
				PH_DATA: begin
					slo_d = nlo; shi_d = nhi;
					ev.has_byte = 1'b1; ev.data = b;
					cnt_d = cnt1;
					if (cnt1 >= flen_q) begin
						cnt_d = '0;
						ev.has_verdict = 1'b1;
						if ({nhi, nlo} != xsum_q) begin
							phase_d = PH_HEAD; ev.verdict = V_NACK; ev.reason = R_SUM;
						end else begin
							total_d = sumtot[23:0];
							xseq_d = xseq_q + 16'd1;
							ev.verdict = V_ACK;
							ev.done = (ftype_q == final_type_code);
							phase_d = ev.done ? PH_DONE : PH_HEAD;
						end
					end
				end
				PH_SKIP: begin
					cnt_d = cnt1;
					if (cnt1 >= flen_q) begin
						cnt_d = '0; phase_d = PH_HEAD;
					end
				end
				default: ;
			endcase
		end
		ev.total = total_d;
		ev.byte_total = total_q;
	end

	assign ev_valid = take && (ev.has_byte || ev.has_verdict);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HS_HEAD; shift_q <= '0; cnt_q <= '0; flen_q <= '0;
			ftype_q <= '0; xsum_q <= '0; slo_q <= '0; shi_q <= '0; xseq_q <= '0;
			total_q <= '0; fcnt_q <= '0; serr_q <= '0;
		end else if (take) begin
			phase_q <= phase_d; shift_q <= shift_d; cnt_q <= cnt_d; flen_q <= flen_d;
			ftype_q <= ftype_d; xsum_q <= xsum_d; slo_q <= slo_d; shi_q <= shi_d;
			xseq_q <= xseq_d; total_q <= total_d; fcnt_q <= fcnt_d; serr_q <= serr_d;
		end
	end

endmodule

FILE: rtl/cfr_emitter.sv
// ----------------------------------------------------------------------------
// cfr_emitter: back part of the receiver
// Holds a short queue of result records and expands each into one or two
// output items.
// ----------------------------------------------------------------------------
module cfr_emitter
	import cfr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      ev_valid,
	input  ev_t       ev,
	output logic      full,
	output logic      empty,
	output logic      valid,
	input  logic      stall,
	output out_item_t result
);

	localparam int AW = $clog2(QDepth);

	ev_t           mem_q [QDepth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          half_q; // byte part already sent
	ev_t           head;
	logic          pop, fire;

	assign head = mem_q[rp_q];
	assign full = (cnt_q == (AW+1)'(QDepth));
	assign empty = (cnt_q == '0);
	assign valid = !empty;
	assign fire = valid && !stall;
	// a record with both parts leaves after its verdict
	assign pop = fire && (half_q || !(head.has_byte && head.has_verdict));

	always_comb begin
		result = '0;
		result.total_length = head.total;
		if (head.has_byte && !half_q) begin
			result.kind = 1'b0;
			result.payload_byte = head.data;
			result.total_length = head.byte_total;
			result.last = !head.has_verdict;
		end else begin
			result.kind = 1'b1;
			result.verdict = head.verdict;
			result.reason = head.reason;
			result.transfer_done = head.done;
			result.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid) mem_q[wp_q] <= ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; half_q <= 1'b0;
		end else begin
			if (ev_valid) wp_q <= wp_q + AW'(1);
			if (pop) rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(ev_valid) - (AW+1)'(pop);
			if (pop) half_q <= 1'b0;
			else if (fire) half_q <= 1'b1;
		end
	end

endmodule

FILE: verif/chunk_frame_receiver_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_frame_receiver_core_tb: self-checking regression of the frame receiver
// Drives handshake and data frames (good, corrupted and random) byte by byte,
// predicts every result item and compares it field by field.
// ----------------------------------------------------------------------------

import cfr_pkg::*;

class frame_scoreboard;
	// register copies
	logic [7:0]  version_r, hs_type_r, final_type_r;
	logic [31:0] magic_r;
	logic [15:0] max_chunk_r;
	logic [23:0] max_total_r;
	// parser copy
	int unsigned ph;
	logic [63:0] shift_r;
	int unsigned cnt, flen, ftype, exp_sum, s_lo, s_hi, exp_seq, total, nframes, seq_errs;
	out_item_t   pending[$];
	int          errors;

	localparam int unsigned P_HS_HEAD = 0, P_HS_MAGIC = 1, P_HEAD = 2, P_SEQ = 3,
		P_DATA = 4, P_SKIP = 5, P_DONE = 6, P_ABORT = 7;

	function new();
		version_r = 8'd1; hs_type_r = 8'd0; final_type_r = 8'd2; magic_r = 32'd0;
		max_chunk_r = 16'd8192; max_total_r = 24'd1048576;
		errors = 0;
		clear();
	endfunction

	function void clear();
		ph = P_HS_HEAD; shift_r = 64'd0; cnt = 0; flen = 0; ftype = 0; exp_sum = 0;
		s_lo = 0; s_hi = 0; exp_seq = 0; total = 0; nframes = 0; seq_errs = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] v);
		case (idx)
			REG_VERSION: version_r = v[7:0];
			REG_HS_TYPE: hs_type_r = v[7:0];
			REG_FINAL_TYPE: final_type_r = v[7:0];
			REG_MAGIC: magic_r = v;
			REG_MAX_CHUNK: max_chunk_r = v[15:0];
			REG_MAX_TOTAL: max_total_r = v[23:0];
			default: ;
		endcase
	endfunction

	function void push(logic k, logic [7:0] pb, logic [1:0] v, logic [3:0] r, logic d);
		out_item_t o;
		o.kind = k; o.payload_byte = pb; o.verdict = v; o.reason = r;
		o.transfer_done = d; o.total_length = total[23:0]; o.last = 1'b0;
		pending.push_back(o);
	endfunction

	function void fold(int unsigned b);
		s_lo = (s_lo + b) % 255;
		s_hi = (s_hi + s_lo) % 255;
	endfunction

	function void close_frame();
		if (((s_hi << 8) | s_lo) != exp_sum) begin
			ph = P_HEAD;
			push(1, 0, V_NACK, R_SUM, 0);
			return;
		end
		total = (total + flen) & 24'hFFFFFF;
		exp_seq = (exp_seq + 1) & 16'hFFFF;
		if (ftype == final_type_r) begin
			ph = P_DONE;
			push(1, 0, V_ACK, R_OK, 1);
		end else begin
			ph = P_HEAD;
			push(1, 0, V_ACK, R_OK, 0);
		end
	endfunction

	// note an accepted input item and queue the results it causes
	function void note_input(in_item_t it);
		int unsigned b, n_prev, why;
		longint unsigned len;
		int unsigned ver, typ;
		b = it.rx_byte;
		n_prev = pending.size();
		if (it.restart) begin
			clear();
			return;
		end
		case (ph)
			P_HS_HEAD, P_HEAD: begin
				if (ph == P_HEAD && cnt == 0 && nframes >= MaxFrames) begin
					ph = P_ABORT;
					push(1, 0, V_SILENT, R_FRAMES, 0);
				end else begin
					if (ph == P_HEAD && cnt == 0) nframes = (nframes + 1) & 14'h3FFF;
					shift_r = {shift_r[55:0], it.rx_byte};
					cnt++;
					if (cnt >= 8) begin
						cnt = 0;
						len = shift_r[63:32];
						ver = shift_r[31:24];
						typ = shift_r[23:16];
						exp_sum = shift_r[15:0];
						ftype = typ;
						shift_r = 0; s_lo = 0; s_hi = 0;
						why = 0;
						if (ph == P_HS_HEAD) begin
							if (ver != version_r) why = R_HS_VER;
							else if (typ != hs_type_r) why = R_HS_TYPE;
							else if (len != 4) why = R_HS_LEN;
							if (why != 0) begin
								ph = P_ABORT;
								push(1, 0, V_SILENT, 4'(why), 0);
							end else ph = P_HS_MAGIC;
						end else begin
							if (ver != version_r) why = R_VER;
							else if (len > max_chunk_r) why = R_CHUNK;
							else if (total + len > max_total_r) why = R_TOTAL;
							if (why != 0) begin
								ph = P_ABORT;
								push(1, 0, V_NACK_ABORT, 4'(why), 0);
							end else begin
								flen = 32'(len & 64'hFFFF);
								ph = P_SEQ;
							end
						end
					end
				end
			end
			P_HS_MAGIC: begin
				fold(b);
				shift_r = {shift_r[55:0], it.rx_byte};
				cnt++;
				if (cnt >= 4) begin
					cnt = 0;
					if (((s_hi << 8) | s_lo) != exp_sum) begin
						ph = P_ABORT;
						push(1, 0, V_SILENT, R_HS_SUM, 0);
					end else if (shift_r[31:0] != magic_r) begin
						ph = P_ABORT;
						push(1, 0, V_SILENT, R_MAGIC, 0);
					end else begin
						exp_seq = 0; total = 0; nframes = 0; seq_errs = 0;
						ph = P_HEAD;
						push(1, 0, V_ACK, R_OK, 0);
					end
					shift_r = 0;
				end
			end
			P_SEQ: begin
				shift_r = {shift_r[55:0], it.rx_byte};
				cnt++;
				if (cnt >= 2) begin
					cnt = 0;
					if (shift_r[15:0] != exp_seq) begin
						if (seq_errs < 15) seq_errs++;
						if (seq_errs >= MaxSeqErrors) begin
							ph = P_ABORT;
							push(1, 0, V_NACK_ABORT, R_SEQ_MANY, 0);
						end else begin
							ph = (flen == 0) ? P_HEAD : P_SKIP;
							push(1, 0, V_NACK, R_SEQ, 0);
						end
					end else begin
						seq_errs = 0;
						if (flen == 0) close_frame();
						else ph = P_DATA;
					end
					shift_r = 0;
				end
			end
			P_DATA: begin
				fold(b);
				push(0, it.rx_byte, V_ACK, R_OK, 0);
				cnt++;
				if (cnt >= flen) begin
					cnt = 0;
					close_frame();
				end
			end
			P_SKIP: begin
				cnt++;
				if (cnt >= flen) begin
					cnt = 0;
					ph = P_HEAD;
				end
			end
			default: ;
		endcase
		if (pending.size() > n_prev) pending[pending.size() - 1].last = 1'b1;
	endfunction

	function void check_result(out_item_t got);
		out_item_t want;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result item %p", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
		end
	endfunction
endclass

module chunk_frame_receiver_core_tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_VERSION;
	logic [31:0] cfg_wdata = '0;

	frame_scoreboard sb = new();
	bit          gaps_on = 1'b1;
	int          idle_cycles = 0;
	int          leftover = 0;
	logic [15:0] tx_seq;
	logic [7:0]  data_buf[$];

	localparam int unsigned WatchdogLimit = 5000;

	chunk_frame_receiver_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: random stall bursts, check on the rising edge
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 19);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WatchdogLimit) begin
			$display("chunk_frame_receiver_core regression: fail");
			$finish;
		end
	end

	// one input item; called at a falling edge, returns at a falling edge with
	// valid still high, so the next item can follow at once
	task automatic send(logic [7:0] b, logic rs = 1'b0);
		int n;
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.rx_byte <= b;
		in_data.restart <= rs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input('{rx_byte: b, restart: rs});
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_header(logic [31:0] len, logic [7:0] ver, logic [7:0] typ,
		logic [15:0] sum);
		send(len[31:24]); send(len[23:16]); send(len[15:8]); send(len[7:0]);
		send(ver); send(typ); send(sum[15:8]); send(sum[7:0]);
	endtask

	function automatic logic [15:0] fletcher(input logic [7:0] q[$]);
		int unsigned lo, hi;
		lo = 0; hi = 0;
		foreach (q[i]) begin
			lo = (lo + q[i]) % 255;
			hi = (hi + lo) % 255;
		end
		return {hi[7:0], lo[7:0]};
	endfunction

	// restart, then a handshake that is good unless a fault is asked for
	task automatic handshake(int fault = 0);
		logic [7:0] m[$];
		logic [15:0] s;
		send(8'($urandom), 1'b1);
		m = '{sb.magic_r[31:24], sb.magic_r[23:16], sb.magic_r[15:8], sb.magic_r[7:0]};
		if (fault == 5) m[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
		s = fletcher(m);
		if (fault == 5) begin
			// keep checksum consistent so the magic compare is what fails
		end
		send_header(fault == 3 ? 32'd5 : 32'd4,
			fault == 1 ? sb.version_r + 8'd1 : sb.version_r,
			fault == 2 ? sb.hs_type_r + 8'd1 : sb.hs_type_r,
			fault == 4 ? s ^ 16'h0100 : s);
		foreach (m[i]) send(m[i]);
		tx_seq = 16'd0;
	endtask

	// a data frame; fault: 0 good, 7 version, 8 chunk, 9 total, 10 seq, 12 sum
	task automatic data_frame(int len, int fault = 0, logic [7:0] typ = 8'd1);
		logic [15:0] s, sq;
		data_buf.delete();
		for (int i = 0; i < len; i++) data_buf.push_back(8'($urandom));
		s = fletcher(data_buf);
		sq = (fault == 10) ? tx_seq + 16'd1 + 16'($urandom_range(0, 300)) : tx_seq;
		send_header(fault == 8 ? 32'(sb.max_chunk_r) + 32'd1 :
			fault == 9 ? 32'(sb.max_total_r) + 32'd1 : 32'(len),
			fault == 7 ? sb.version_r ^ 8'h80 : sb.version_r,
			typ, fault == 12 ? s ^ 16'h0001 : s);
		send(sq[15:8]); send(sq[7:0]);
		foreach (data_buf[i]) send(data_buf[i]);
		if (fault == 0) tx_seq++;
	endtask

	initial begin
		int k, r;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset registers, then every fault path but the frame-count limit
		handshake();
		data_frame(0);
		data_frame(3, 12);
		data_frame(2, 10);
		data_frame(1);
		data_frame(2, 0, 8'd2);
		send(8'hFF);
		for (int f = 1; f <= 5; f++) begin
			handshake(f);
			send(8'h00);
		end
		handshake(); data_frame(1, 7);
		handshake(); data_frame(1, 8);
		handshake(); data_frame(1, 9);
		handshake();
		for (int i = 0; i < 10; i++) data_frame(0, 10);

		// extremes of the registers
		write_reg(REG_VERSION, 32'hFF);
		write_reg(REG_HS_TYPE, 32'hFF);
		write_reg(REG_FINAL_TYPE, 32'hFF);
		write_reg(REG_MAGIC, 32'hFFFF_FFFF);
		write_reg(REG_MAX_CHUNK, 32'h1);
		write_reg(REG_MAX_TOTAL, 32'h3);
		handshake();
		data_frame(1); data_frame(1); data_frame(1, 0, 8'hFF);
		handshake(); data_frame(1); data_frame(1); data_frame(1, 9);
		write_reg(REG_MAX_CHUNK, 32'hFFFF);
		write_reg(REG_MAX_TOTAL, 32'hFF_FFFF);
		write_reg(REG_VERSION, 32'h0);
		write_reg(REG_HS_TYPE, 32'h0);
		write_reg(REG_MAGIC, 32'h0);
		handshake(); data_frame(4);

		// hold the sender until every result is out
		drain();

		write_reg(REG_VERSION, 32'($urandom_range(0, 255)));
		write_reg(REG_HS_TYPE, 32'($urandom_range(0, 255)));
		write_reg(REG_FINAL_TYPE, 32'd7);
		write_reg(REG_MAGIC, $urandom);
		write_reg(REG_MAX_CHUNK, 32'd12);
		write_reg(REG_MAX_TOTAL, 32'd200);

		// random: mostly well-formed transfers, with faults and noise
		k = 0;
		while (k < 360) begin
			if (k > 290) gaps_on = 1'b0;
			r = $urandom_range(0, 19);
			if (r == 0) begin
				handshake($urandom_range(1, 5));
				send(8'($urandom));
				k += 14;
			end else if (r == 1 || sb.ph >= 6 || sb.ph < 2) begin
				handshake();
				k += 13;
			end else if (r == 2) begin
				send(8'($urandom), 1'($urandom));
				k++;
			end else begin
				int f, len;
				len = $urandom_range(0, 9) == 0 ? 12 : $urandom_range(0, 5);
				case ($urandom_range(0, 15))
					0: f = 12;
					1: f = 10;
					2: f = 8;
					3: f = 7;
					default: f = 0;
				endcase
				data_frame(len, f, $urandom_range(0, 11) == 0 ? 8'd7 :
					8'($urandom_range(0, 6)));
				k += 10 + len;
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("chunk_frame_receiver_core regression: pass");
		else
			$display("chunk_frame_receiver_core regression: fail");
		$finish;
	end
endmodule
